[sv/istr_pkg.sv]
// Shared types, constants and helpers for the interpolating sample table read block.
package istr_pkg;

   // Field widths fixed by the item format
   localparam int SAMPLE_W    = 16;
   localparam int FRAC_W      = 16;
   localparam int WHOLE_W     = 16;
   localparam int LENGTH_W    = 17;
   localparam int COUNT_W     = 2;
   localparam int SRC_W       = 2;
   localparam int OUT_CHAN_W  = 3;
   localparam int ACC_W       = 24;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 17;

   // Item commands
   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_READ  = 1'b1
   } command_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SAMPLE_LENGTH = 1'b0,
      CSR_CHANNEL_COUNT = 1'b1
   } csr_index_type;

   // Request item
   typedef struct packed {
      command_type                command;
      logic                       write_channel;
      logic [WHOLE_W-1:0]         write_address;
      logic signed [SAMPLE_W-1:0] write_value;
      logic [WHOLE_W-1:0]         index_whole;
      logic [FRAC_W-1:0]          index_frac;
      logic [OUT_CHAN_W-1:0]      out_channel;
      logic                       loop_mode;
      logic signed [ACC_W-1:0]    acc_in;
   } req_payload_type;

   // Response item
   typedef struct packed {
      logic signed [ACC_W-1:0] acc_out;
      logic                    out_of_range;
   } rsp_payload_type;

   // Source channel: output channel modulo the effective channel count (1..3)
   function automatic logic [SRC_W-1:0] src_channel(input logic [OUT_CHAN_W-1:0] ochan,
                                                    input logic [COUNT_W-1:0] count);
      logic [SRC_W-1:0] res;
      res = '0;
      case (count)
         2'd2: res = {1'b0, ochan[0]};
         2'd3: begin
            case (ochan)
               3'd0, 3'd3, 3'd6: res = 2'd0;
               3'd1, 3'd4, 3'd7: res = 2'd1;
               default:          res = 2'd2;
            endcase
         end
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

[sv/istr_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
module istr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one word, read two words; read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

[sv/interpolating_sample_table_read.sv]
// Top level: multichannel sample memory with linear-interpolating accumulate read.
//
// Usage:
//   Request channel (req_valid / req_stall / req_payload) carries write items
//   (command write: store write_value at write_channel, write_address) and read
//   items (command read: interpolate at index_whole.index_frac on source channel
//   out_channel mod channel_count, add to acc_in and saturate).
//   Response channel (rsp_valid / rsp_stall / rsp_payload) returns one item per
//   read; writes return nothing. A position at or past the sample length gives
//   out_of_range = 1 and acc_out = acc_in.
//   A read passes through the RAM read, multiply, interpolate and accumulate
//   steps into the output register.
//   Throughput: one item per cycle while req_stall is low, carried by the two
//   read ports of the sample RAM, which fetch both neighboring frames at once.
//   A write is stored at the edge that takes it, so a read in the next cycle
//   already sees it.
//   Reset clears the pipeline and sets sample_length and channel_count to 1.
//   Sample memory contents are not cleared and are undefined until written.
//   When the receiver stalls, the output register holds its item and earlier
//   stages keep filling; req_stall rises only once every stage is occupied.
//   The user must write configuration (csr_*) only while no read is in flight; the block does not enforce it.
module interpolating_sample_table_read #(
   parameter int MAX_LENGTH   = 65536,
   parameter int MAX_CHANNELS = 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  istr_pkg::req_payload_type              req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output istr_pkg::rsp_payload_type              rsp_payload,
   input  logic                                   csr_write_en,
   input  logic [istr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [istr_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import istr_pkg::*;

   localparam int DEPTH = MAX_CHANNELS * MAX_LENGTH;
   localparam int AW    = $clog2(DEPTH);

   // Configuration, stored already clamped to the legal range
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   // Pipeline handshake
   logic ready_out, ready3, ready2, ready1;
   logic req_take, is_read;

   // Stage 0 (issue)
   logic [LENGTH_W-1:0] whole_ext, plus_one, next_idx;
   logic                oor;
   logic [SRC_W-1:0]    src;
   logic                wr_ok;
   logic                ram_wr_en, ram_rd_en;
   logic [AW-1:0]       ram_wr_addr, ram_rd_addr_a, ram_rd_addr_b;
   logic [SAMPLE_W-1:0] ram_rd_data_a, ram_rd_data_b;

   // Stage 1 (RAM data, multiply)
   logic                    s1_valid_ff;
   logic                    s1_oor_ff;
   logic [FRAC_W-1:0]       s1_frac_ff;
   logic signed [ACC_W-1:0] s1_acc_ff;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [2*SAMPLE_W+1:0] prod_in;

   // Stage 2 (round, interpolate)
   logic                         s2_valid_ff;
   logic                         s2_oor_ff;
   logic signed [ACC_W-1:0]      s2_acc_ff;
   logic signed [2*SAMPLE_W+1:0] prod_ff;
   logic signed [SAMPLE_W-1:0]   base_ff;
   logic signed [2*SAMPLE_W+1:0] rounded;
   logic signed [SAMPLE_W+1:0]   step;
   logic signed [SAMPLE_W:0]     interp_in;

   // Stage 3 (accumulate, saturate)
   logic                       s3_valid_ff;
   logic                       s3_oor_ff;
   logic signed [ACC_W-1:0]    s3_acc_ff;
   logic signed [SAMPLE_W:0]   s3_interp_ff;
   logic signed [ACC_W:0]      sum;
   logic signed [ACC_W-1:0]    acc_sat;

   // Output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   // Clamp configuration values on the way in
   always_comb begin
      if (32'(csr_wdata[LENGTH_W-1:0]) > 32'(MAX_LENGTH)) begin
         length_in = LENGTH_W'(MAX_LENGTH);
      end else begin
         length_in = csr_wdata[LENGTH_W-1:0];
      end
      if (csr_wdata[COUNT_W-1:0] == '0) begin
         count_in = COUNT_W'(1);
      end else if (32'(csr_wdata[COUNT_W-1:0]) > 32'(MAX_CHANNELS)) begin
         count_in = COUNT_W'(MAX_CHANNELS);
      end else begin
         count_in = csr_wdata[COUNT_W-1:0];
      end
   end

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_W'(1);
         count_ff  <= COUNT_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SAMPLE_LENGTH: length_ff <= length_in;
            CSR_CHANNEL_COUNT: count_ff  <= count_in;
         endcase
      end
   end

   // Advance each stage when the one after it is free or moving
   assign ready_out = !rsp_valid_ff || !rsp_stall;
   assign ready3    = !s3_valid_ff || ready_out;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1;
   assign req_take  = req_valid && ready1;
   assign is_read   = req_payload.command == CMD_READ;

   // Decode position, neighbor frame and memory addresses
   always_comb begin
      whole_ext = {1'b0, req_payload.index_whole};
      oor       = whole_ext >= length_ff;
      plus_one  = whole_ext + LENGTH_W'(1);
      if (plus_one >= length_ff) begin
         next_idx = req_payload.loop_mode ? '0 : length_ff - LENGTH_W'(1);
      end else begin
         next_idx = plus_one;
      end
      src = src_channel(req_payload.out_channel, count_ff);
      ram_rd_addr_a = AW'(32'(src) * 32'(MAX_LENGTH) + 32'(whole_ext));
      ram_rd_addr_b = AW'(32'(src) * 32'(MAX_LENGTH) + 32'(next_idx));
      wr_ok = (32'(req_payload.write_channel) < 32'(MAX_CHANNELS))
              && (32'(req_payload.write_address) < 32'(MAX_LENGTH));
      ram_wr_addr = AW'(32'(req_payload.write_channel) * 32'(MAX_LENGTH)
                        + 32'(req_payload.write_address));
   end

   assign ram_wr_en = req_take && !is_read && wr_ok;
   assign ram_rd_en = req_take && is_read && !oor;

   istr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_sample_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (req_payload.write_value),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

   // Stage 1: track the read alongside the RAM access
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ready1) begin
         s1_valid_ff <= req_take && is_read;
      end
      if (req_take && is_read) begin
         s1_oor_ff  <= oor;
         s1_frac_ff <= req_payload.index_frac;
         s1_acc_ff  <= req_payload.acc_in;
      end
   end

   // Multiply the frame difference by the fraction
   always_comb begin
      diff    = (SAMPLE_W+1)'($signed(ram_rd_data_b)) - (SAMPLE_W+1)'($signed(ram_rd_data_a));
      prod_in = diff * $signed({1'b0, s1_frac_ff});
   end

   // Stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ready2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff && ready2) begin
         s2_oor_ff <= s1_oor_ff;
         s2_acc_ff <= s1_acc_ff;
         prod_ff   <= prod_in;
         base_ff   <= $signed(ram_rd_data_a);
      end
   end

   // Round half up and add to the base frame
   always_comb begin
      rounded   = prod_ff + (2*SAMPLE_W+2)'(32768);
      step      = rounded[2*SAMPLE_W+1:FRAC_W];
      interp_in = (SAMPLE_W+1)'(base_ff) + (SAMPLE_W+1)'(step);
   end

   // Stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ready3) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s2_valid_ff && ready3) begin
         s3_oor_ff    <= s2_oor_ff;
         s3_acc_ff    <= s2_acc_ff;
         s3_interp_ff <= interp_in;
      end
   end

   // Accumulate and saturate; drop the sample when out of range
   always_comb begin
      sum = (ACC_W+1)'(s3_acc_ff) + (s3_oor_ff ? '0 : (ACC_W+1)'(s3_interp_ff));
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         acc_sat = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_sat = sum[ACC_W-1:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready_out) begin
         rsp_valid_ff <= s3_valid_ff;
      end
      if (s3_valid_ff && ready_out) begin
         rsp_payload_ff.acc_out      <= acc_sat;
         rsp_payload_ff.out_of_range <= s3_oor_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff))
      else $error("response appeared without a finished item");

   a_full_pipe_stalls: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && s1_valid_ff && s2_valid_ff && s3_valid_ff)
      |-> req_stall)
      else $error("request taken while every stage is held");

   a_oor_passthrough: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_oor_ff && ready_out)
      |=> (rsp_payload_ff.acc_out == $past(s3_acc_ff) && rsp_payload_ff.out_of_range))
      else $error("out-of-range read changed the accumulator");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd0)
      else $error("effective channel count is zero");
`endif

endmodule

[verif/tb_interpolating_sample_table_read.sv]
// Self-checking testbench for the interpolating sample table read block.
`timescale 1ns / 100ps

import istr_pkg::*;

// Tracks the sample memory and registers and predicts each interpolated sum
class interp_accumulator;
   localparam int FRAMES = 65536;
   localparam int CHANNELS = 2;
   localparam longint SUM_MAX = 64'sd8388607;
   localparam longint SUM_MIN = -64'sd8388608;

   logic signed [SAMPLE_W-1:0] frames [int];
   rsp_payload_type expected_sums [$];
   int unsigned length_reg;
   int unsigned count_reg;
   int errors;
   int reads;
   int writes;
   int clipped;
   int beyond_end;

   function new();
      length_reg = 1;
      count_reg = 1;
      errors = 0;
      reads = 0;
      writes = 0;
      clipped = 0;
      beyond_end = 0;
   endfunction

   function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      if (idx == CSR_SAMPLE_LENGTH)
         length_reg = value;
      else
         count_reg = value[COUNT_W-1:0];
   endfunction

   // Clamp the length register to the frames per channel
   function int unsigned eff_length();
      return (length_reg > FRAMES) ? FRAMES : length_reg;
   endfunction

   function int unsigned source_of(logic [OUT_CHAN_W-1:0] ochan);
      int unsigned cc;
      cc = (count_reg == 0) ? 1 : ((count_reg > CHANNELS) ? CHANNELS : count_reg);
      return ochan % cc;
   endfunction

   // Wrap to frame zero when looping, else hold the last frame
   function int unsigned next_frame(int unsigned whole, logic loop_mode);
      int unsigned len;
      int unsigned nxt;
      len = eff_length();
      nxt = whole + 1;
      if (nxt >= len)
         nxt = loop_mode ? 0 : len - 1;
      return nxt;
   endfunction

   function bit has_frame(int unsigned ch, int unsigned addr);
      return frames.exists(ch * FRAMES + addr);
   endfunction

   function longint frame(int unsigned ch, int unsigned addr);
      if (!has_frame(ch, addr))
         return 0;
      return frames[ch * FRAMES + addr];
   endfunction

   // Apply one accepted request: store a write, or queue the expected sum of a read
   function void take_request(req_payload_type r);
      rsp_payload_type e;
      int unsigned len;
      int unsigned src;
      int unsigned nxt;
      longint s0;
      longint s1;
      longint f;
      longint mix;
      longint sum;
      if (r.command == CMD_WRITE) begin
         frames[int'(r.write_channel) * FRAMES + int'(r.write_address)] = r.write_value;
         writes++;
         return;
      end
      reads++;
      len = eff_length();
      if (r.index_whole >= len) begin
         e.acc_out = r.acc_in;
         e.out_of_range = 1'b1;
         beyond_end++;
         expected_sums.push_back(e);
         return;
      end
      src = source_of(r.out_channel);
      nxt = next_frame(r.index_whole, r.loop_mode);
      s0 = frame(src, r.index_whole);
      s1 = frame(src, nxt);
      f = r.index_frac;
      // Q1.31 blend, round half up back to Q1.15
      mix = (s0 * (65536 - f) + s1 * f + 32768) >>> 16;
      sum = longint'(r.acc_in) + mix;
      if (sum > SUM_MAX) begin
         sum = SUM_MAX;
         clipped++;
      end
      if (sum < SUM_MIN) begin
         sum = SUM_MIN;
         clipped++;
      end
      e.acc_out = sum[ACC_W-1:0];
      e.out_of_range = 1'b0;
      expected_sums.push_back(e);
   endfunction

   function void check_response(rsp_payload_type got);
      rsp_payload_type e;
      if (expected_sums.size() == 0) begin
         errors++;
         $display("%0t: response with nothing expected: acc_out=%0d out_of_range=%0b",
                  $time, got.acc_out, got.out_of_range);
         return;
      end
      e = expected_sums.pop_front();
      if (got.acc_out !== e.acc_out) begin
         errors++;
         $display("%0t: acc_out mismatch: expected %0d, got %0d",
                  $time, e.acc_out, got.acc_out);
      end
      if (got.out_of_range !== e.out_of_range) begin
         errors++;
         $display("%0t: out_of_range mismatch: expected %0b, got %0b",
                  $time, e.out_of_range, got.out_of_range);
      end
   endfunction

   function int pending();
      return expected_sums.size();
   endfunction
endclass

module tb_interpolating_sample_table_read;
   localparam int SETTLE_CYCLES = 8;
   localparam int ITEM_TARGET = 1700;
   localparam int PHASE_ITEMS = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit steady = 1'b0;
   int items_sent = 0;
   int phases = 0;
   int stall_left = 0;
   interp_accumulator accum = new();

   interpolating_sample_table_read DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Record every transfer on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            accum.take_request(req_payload);
         if (rsp_valid && !rsp_stall)
            accum.check_response(rsp_payload);
      end
   end

   // Mostly short gaps, a few long ones, none in steady phases
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Receiver backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0)
            stall_left <= pick_gap();
      end
   end

   // Hold the item until it transfers, then idle for a random gap
   task automatic send(req_payload_type p);
      int gap;
      req_payload = p;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Random filler so unused fields toggle too
   function automatic req_payload_type noise();
      logic [95:0] bits;
      bits = {$urandom, $urandom, $urandom};
      return bits[$bits(req_payload_type)-1:0];
   endfunction

   task automatic write_frame(int unsigned ch, int unsigned addr, logic signed [15:0] value);
      req_payload_type p;
      p = noise();
      p.command = CMD_WRITE;
      p.write_channel = ch[0];
      p.write_address = addr[15:0];
      p.write_value = value;
      send(p);
   endtask

   task automatic read_at(int unsigned whole, logic [15:0] frac, logic [2:0] ochan,
                          logic loop_mode, logic signed [23:0] acc);
      req_payload_type p;
      p = noise();
      p.command = CMD_READ;
      p.index_whole = whole[15:0];
      p.index_frac = frac;
      p.out_channel = ochan;
      p.loop_mode = loop_mode;
      p.acc_in = acc;
      send(p);
   endtask

   // Write both neighbors first so the read never touches an unwritten frame
   task automatic read_filled(int unsigned whole, logic [15:0] frac, logic [2:0] ochan,
                              logic loop_mode, logic signed [23:0] acc);
      int unsigned src;
      int unsigned nxt;
      src = accum.source_of(ochan);
      nxt = accum.next_frame(whole, loop_mode);
      if (!accum.has_frame(src, whole))
         write_frame(src, whole, 16'($urandom));
      if (!accum.has_frame(src, nxt))
         write_frame(src, nxt, 16'($urandom));
      read_at(whole, frac, ochan, loop_mode, acc);
   endtask

   task automatic write_register(csr_index_type idx, int unsigned value);
      csr_index = idx;
      csr_wdata = value[CSR_DATA_W-1:0];
      csr_write_en = 1'b1;
      @(negedge clock);
      csr_write_en = 1'b0;
      accum.set_register(idx, value[CSR_DATA_W-1:0]);
   endtask

   // Hold off the sender until every read has answered and the pipe is empty
   task automatic drain();
      req_valid = 1'b0;
      while (accum.pending() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_phase(int unsigned length, int unsigned count);
      drain();
      write_register(CSR_SAMPLE_LENGTH, length);
      write_register(CSR_CHANNEL_COUNT, count);
      phases++;
   endtask

   function automatic int unsigned pick_length(int p);
      int roll;
      if (p == 0)
         return 1;
      if (p == 1)
         return 65536;
      roll = $urandom_range(0, 99);
      if (roll < 45)
         return $urandom_range(1, 8);
      if (roll < 65)
         return $urandom_range(9, 300);
      if (roll < 75)
         return 65536;
      if (roll < 83)
         return $urandom_range(65537, 131071);
      if (roll < 90)
         return 0;
      return $urandom_range(0, 131071);
   endfunction

   // Mostly in-range reads with frames filled in, plus stray writes and reads past the end
   task automatic random_item();
      int unsigned len;
      int unsigned roll;
      int unsigned whole;
      logic signed [23:0] acc;
      len = accum.eff_length();
      roll = $urandom_range(0, 99);
      acc = 24'($urandom);
      if ($urandom_range(0, 9) == 0)
         acc = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      if (roll < 12) begin
         write_frame($urandom_range(0, 1), $urandom_range(0, 65535), 16'($urandom));
      end else if (len == 0 || (roll < 26 && len < 65536)) begin
         read_at($urandom_range(len, 65535), 16'($urandom), 3'($urandom), 1'($urandom), acc);
      end else begin
         if (roll < 50)
            whole = len - 1;
         else if (roll < 58)
            whole = 0;
         else
            whole = $urandom_range(0, len - 1);
         read_filled(whole, 16'($urandom), 3'($urandom), 1'($urandom), acc);
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Four frames on each of two channels, including full-scale values
      set_phase(4, 2);
      write_frame(0, 0, 16'sh7FFF);
      write_frame(0, 1, 16'sh8000);
      write_frame(0, 2, 16'sh0000);
      write_frame(0, 3, 16'shFFFF);
      write_frame(1, 0, 16'sh8000);
      write_frame(1, 1, 16'sh7FFF);
      write_frame(1, 2, 16'sh0064);
      write_frame(1, 3, 16'sh7FFF);
      read_at(0, 16'h0000, 3'd0, 1'b0, 24'sh000000);
      read_at(0, 16'hFFFF, 3'd0, 1'b0, 24'sh000000);
      read_at(1, 16'h8000, 3'd2, 1'b0, 24'sh000000);
      // end of sample: wrap, then hold
      read_at(3, 16'h8000, 3'd0, 1'b1, 24'sh000000);
      read_at(3, 16'h8000, 3'd0, 1'b0, 24'sh000000);
      // saturate high and low on channel 1
      read_at(1, 16'h0000, 3'd7, 1'b0, 24'sh7FFFFF);
      read_at(0, 16'h0000, 3'd5, 1'b0, 24'sh800000);
      // past the end, with and without looping
      read_at(4, 16'h1234, 3'd6, 1'b1, 24'sh123456);
      read_at(16'hFFFF, 16'hFFFF, 3'd3, 1'b0, 24'sh7FFFFF);

      // Oversized length and channel count clamp to the memory size
      set_phase(131071, 3);
      read_filled(65535, 16'hFFFF, 3'd1, 1'b1, 24'sh000000);
      read_filled(65535, 16'h8000, 3'd7, 1'b0, 24'sh800000);

      // Zero length puts every read out of range; zero count acts as one
      set_phase(0, 0);
      read_at(0, 16'h0000, 3'd0, 1'b1, 24'sh000001);

      // Random phases, each under a fresh register setting; stop near the item target
      for (int p = 0; items_sent < ITEM_TARGET; p++) begin
         steady = (p % 4 == 3);
         set_phase(pick_length(p), (p == 0) ? 1 : $urandom_range(0, 3));
         for (int i = 0; i < PHASE_ITEMS && items_sent < ITEM_TARGET; i++)
            random_item();
      end

      steady = 1'b0;
      drain();
      $display("Ran %0d reads (%0d past the end, %0d clipped) and %0d writes",
               accum.reads, accum.beyond_end, accum.clipped, accum.writes);
      $display("across %0d register settings with random gaps and receiver stalls.", phases);
      if (accum.errors == 0 && accum.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule

[interpolating_sample_table_read.f]
sv/istr_pkg.sv
sv/istr_ram.sv
sv/interpolating_sample_table_read.sv
verif/tb_interpolating_sample_table_read.sv
